@@ rtl/assert_macros.svh @@
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that holds at every edge out of reset
`define GDA_ASSERT(lbl, ck, rn, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) prop) else $error(msg);

// consequent checked in the cycle after the antecedent
`define GDA_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/gda_pkg.sv @@
package gda_pkg;

  localparam int DIFF_W     = 23;
  localparam int YEAR_SHIFT = 400;
  localparam int ERA_DAYS   = 146097;
  localparam int YEAR_DAYS  = 365;
  // serial of 0-01-01
  localparam int LO_SER     = 146037;
  // serial of 1900-01-01 modulo 7
  localparam int EPOCH_MOD7 = 5;

  localparam logic [1:0] KIND_SHIFT = 2'd0;
  localparam logic [1:0] KIND_DIFF  = 2'd1;
  localparam logic [1:0] KIND_WDAY  = 2'd2;

  localparam logic [8:0] K_ERA_END = 9'd400;
  localparam logic [3:0] MP_LAST   = 4'd11;

  localparam logic signed [DIFF_W-1:0] DIFF_MAX = {1'b0, {(DIFF_W-1){1'b1}}};
  localparam logic signed [DIFF_W-1:0] DIFF_MIN = {1'b1, {(DIFF_W-1){1'b0}}};

  typedef enum logic [2:0] {
    ALU_HOLD,
    ALU_LOAD,
    ALU_ADD,
    ALU_SUB,
    ALU_SUB_GE,
    ALU_MAX,
    ALU_MIN
  } gda_alu_op_t;

  // calendar month length, february counted as 29
  function automatic logic [4:0] month_days(input logic [3:0] m);
    logic [4:0] len;
    case (m)
      4'd2:                     len = 5'd29;
      4'd4, 4'd6, 4'd9, 4'd11:  len = 5'd30;
      default:                  len = 5'd31;
    endcase
    return len;
  endfunction

  function automatic logic date_range_ok(input logic [3:0] m, input logic [4:0] d);
    return (m inside {[4'd1:4'd12]}) && (d != 5'd0) && (d <= month_days(m));
  endfunction

  // first day of a march-based month within its year
  function automatic logic [8:0] march_start(input logic [3:0] mp);
    logic [8:0] s;
    case (mp)
      4'd0:    s = 9'd0;
      4'd1:    s = 9'd31;
      4'd2:    s = 9'd61;
      4'd3:    s = 9'd92;
      4'd4:    s = 9'd122;
      4'd5:    s = 9'd153;
      4'd6:    s = 9'd184;
      4'd7:    s = 9'd214;
      4'd8:    s = 9'd245;
      4'd9:    s = 9'd275;
      4'd10:   s = 9'd306;
      4'd11:   s = 9'd337;
      default: s = 9'd0;
    endcase
    return s;
  endfunction

  function automatic logic [4:0] march_len(input logic [3:0] mp);
    logic [4:0] len;
    case (mp)
      4'd1, 4'd3, 4'd6, 4'd8: len = 5'd30;
      4'd11:                  len = 5'd29;
      default:                len = 5'd31;
    endcase
    return len;
  endfunction

  function automatic logic [2:0] mod7_step(input logic [3:0] v);
    return (v >= 4'd7) ? 3'(v - 4'd7) : v[2:0];
  endfunction

endpackage

@@ rtl/gda_if.sv @@
interface gda_in_if;
  logic                valid;
  logic                ready;
  logic [1:0]          kind;
  logic [13:0]         year_a;
  logic [3:0]          month_a;
  logic [4:0]          day_a;
  logic signed [22:0]  offset_days;
  logic [13:0]         year_b;
  logic [3:0]          month_b;
  logic [4:0]          day_b;

  modport source (
    output valid, kind, year_a, month_a, day_a, offset_days, year_b, month_b, day_b,
    input  ready
  );
  modport sink (
    input  valid, kind, year_a, month_a, day_a, offset_days, year_b, month_b, day_b,
    output ready
  );
endinterface

interface gda_out_if;
  logic                valid;
  logic                ready;
  logic [13:0]         result_year;
  logic [3:0]          result_month;
  logic [4:0]          result_day;
  logic signed [22:0]  day_difference;
  logic [2:0]          weekday;
  logic                date_invalid;
  logic                year_overflow;

  modport source (
    output valid, result_year, result_month, result_day, day_difference, weekday,
           date_invalid, year_overflow,
    input  ready
  );
  modport sink (
    input  valid, result_year, result_month, result_day, day_difference, weekday,
           date_invalid, year_overflow,
    output ready
  );
endinterface

@@ rtl/gda_alu.sv @@
`include "assert_macros.svh"

module gda_alu
  import gda_pkg::*;
#(
  parameter int W = 25
) (
  input  logic                clk,
  input  logic                rst_n,
  input  gda_alu_op_t         op,
  input  logic signed [W-1:0] b,
  output logic signed [W-1:0] acc,
  output logic                hit
);

  logic signed [W-1:0] acc_r;
  logic signed [W-1:0] acc_nxt;
  logic signed [W-1:0] opnd;
  logic                cin;
  logic signed [W-1:0] sum;

  always_comb begin
    opnd = b;
    cin  = 1'b0;
    case (op)
      ALU_SUB, ALU_SUB_GE, ALU_MAX: begin
        opnd = ~b;
        cin  = 1'b1;
      end
      // acc - b - 1, non-negative when acc is above b
      ALU_MIN: begin
        opnd = ~b;
        cin  = 1'b0;
      end
      default: begin
        opnd = b;
        cin  = 1'b0;
      end
    endcase
  end

  assign sum = acc_r + opnd + W'(cin);

  always_comb begin
    hit     = 1'b0;
    acc_nxt = acc_r;
    case (op)
      ALU_LOAD:   acc_nxt = b;
      ALU_ADD:    acc_nxt = sum;
      ALU_SUB:    acc_nxt = sum;
      ALU_SUB_GE: begin
        hit = !sum[W-1];
        if (hit) acc_nxt = sum;
      end
      ALU_MAX: begin
        hit = sum[W-1];
        if (hit) acc_nxt = b;
      end
      ALU_MIN: begin
        hit = !sum[W-1];
        if (hit) acc_nxt = b;
      end
      default: acc_nxt = acc_r;
    endcase
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  assign acc = acc_r;

  `GDA_ASSERT_NEXT(a_sub_ge_nonneg, clk, rst_n, (op == ALU_SUB_GE) && hit, !acc_r[W-1], "trial subtract left a negative remainder")
  `GDA_ASSERT_NEXT(a_min_bound, clk, rst_n, (op == ALU_MIN) && hit, acc_r == $past(b), "upper clamp did not load the bound")
  `GDA_ASSERT_NEXT(a_max_bound, clk, rst_n, (op == ALU_MAX) && hit, acc_r == $past(b), "lower clamp did not load the bound")

endmodule

@@ rtl/gregorian_date_arithmetic_unit.sv @@
// channel   dir  handshake        payload
// in_chan   in   valid / ready    kind, date a, offset_days, date b
// out_chan  out  valid / ready    shifted date, day_difference, weekday, flags
//
// one request at a time through a single accumulator adder under a sequencer.
// a date to day serial: load the day of year, then add whole eras, then single years.
// serial back to a date: subtract whole eras, then single years, then march-based months.
// rst_n is synchronous; the result register lets a new request in while out_chan stalls.
`include "assert_macros.svh"

module gregorian_date_arithmetic_unit
  import gda_pkg::*;
#(
  parameter int MAX_YEAR = 9999
) (
  input  logic      clk,
  input  logic      rst_n,
  gda_in_if.sink    in_chan,
  gda_out_if.source out_chan
);

  localparam int YALL   = (MAX_YEAR > 16383) ? MAX_YEAR : 16383;
  localparam int SER_W  = $clog2((YALL + 401) * 366 + 1);
  localparam int ACC_W  = SER_W + 2;
  localparam int YC_W   = $clog2(YALL + 802);
  localparam int NDIG   = (SER_W + 2) / 3;
  localparam int PAD_W  = 3 * NDIG;
  localparam int PB_W   = $clog2(PAD_W);
  localparam int BI_W   = $clog2(NDIG);
  localparam int HI_YS  = MAX_YEAR + 400;
  localparam int HI_SER = HI_YS * 365 + HI_YS / 4 - HI_YS / 100 + HI_YS / 400 + 305;

  typedef enum logic [13:0] {
    S_IDLE  = 14'b00000000000001,
    S_LOAD  = 14'b00000000000010,
    S_ERA   = 14'b00000000000100,
    S_YEAR  = 14'b00000000001000,
    S_SHIFT = 14'b00000000010000,
    S_CLO   = 14'b00000000100000,
    S_CHI   = 14'b00000001000000,
    S_FERA  = 14'b00000010000000,
    S_FYEAR = 14'b00000100000000,
    S_FMON  = 14'b00001000000000,
    S_DIFF  = 14'b00010000000000,
    S_SAT   = 14'b00100000000000,
    S_MOD   = 14'b01000000000000,
    S_DONE  = 14'b10000000000000
  } gda_state_t;

  gda_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  logic [1:0]               kind_r, kind_nxt;
  logic [13:0]              ya_r, ya_nxt, yb_r, yb_nxt;
  logic [3:0]               ma_r, ma_nxt, mb_r, mb_nxt;
  logic [4:0]               da_r, da_nxt, db_r, db_nxt;
  logic signed [DIFF_W-1:0] off_r, off_nxt;
  logic                     sel_b_r, sel_b_nxt;
  logic                     bad_r, bad_nxt;
  logic [YC_W-1:0]          yc_r, yc_nxt;
  logic [8:0]               k_r, k_nxt;
  logic [6:0]               k100_r, k100_nxt;
  logic [3:0]               mp_r, mp_nxt;
  logic [BI_W-1:0]          bi_r, bi_nxt;
  logic [2:0]               r7_r, r7_nxt;
  logic signed [ACC_W-1:0]  save_r, save_nxt;

  logic [13:0]              wk_year_r, wk_year_nxt;
  logic [3:0]               wk_month_r, wk_month_nxt;
  logic [4:0]               wk_day_r, wk_day_nxt;
  logic signed [DIFF_W-1:0] wk_diff_r, wk_diff_nxt;
  logic [2:0]               wk_wday_r, wk_wday_nxt;
  logic                     wk_inv_r, wk_inv_nxt;
  logic                     wk_ovf_r, wk_ovf_nxt;

  logic [13:0]              o_year_r, o_year_nxt;
  logic [3:0]               o_month_r, o_month_nxt;
  logic [4:0]               o_day_r, o_day_nxt;
  logic signed [DIFF_W-1:0] o_diff_r, o_diff_nxt;
  logic [2:0]               o_wday_r, o_wday_nxt;
  logic                     o_inv_r, o_inv_nxt;
  logic                     o_ovf_r, o_ovf_nxt;

  gda_alu_op_t             alu_op;
  logic signed [ACC_W-1:0] alu_b;
  logic signed [ACC_W-1:0] acc;
  logic                    alu_hit;

  gda_alu #(
    .W (ACC_W)
  ) u_alu (
    .clk   (clk),
    .rst_n (rst_n),
    .op    (alu_op),
    .b     (alu_b),
    .acc   (acc),
    .hit   (alu_hit)
  );

  logic [13:0]      cur_y;
  logic [3:0]       cur_m;
  logic [4:0]       cur_d;
  logic [3:0]       cur_mp;
  logic [8:0]       cur_doy;
  logic             leap_k;
  logic [3:0]       res_mm;
  logic [YC_W-1:0]  res_yy;
  logic [SER_W-1:0] ser_bits;
  logic [PAD_W-1:0] ser_pad;
  logic [PB_W-1:0]  dig_base;
  logic [2:0]       ser_dig;
  logic [2:0]       r7_step;
  logic             diff_fits;
  logic             feb_bad;

  assign cur_y   = sel_b_r ? yb_r : ya_r;
  assign cur_m   = sel_b_r ? mb_r : ma_r;
  assign cur_d   = sel_b_r ? db_r : da_r;
  assign cur_mp  = (cur_m >= 4'd3) ? (cur_m - 4'd3) : (cur_m + 4'd9);
  assign cur_doy = march_start(cur_mp) + {4'd0, cur_d} - 9'd1;

  // k counts years within a 400-year era, k100 tracks k modulo 100
  assign leap_k  = (k_r[1:0] == 2'b00) && ((k100_r != 7'd0) || (k_r == K_ERA_END));
  // at the end of the year walk k is the calendar year modulo 400 of a jan/feb date
  assign feb_bad = (cur_m == 4'd2) && (cur_d == 5'd29) && !leap_k;

  assign res_mm = (mp_r < 4'd10) ? (mp_r + 4'd3) : (mp_r - 4'd9);
  assign res_yy = yc_r + YC_W'(k_r) + YC_W'(mp_r >= 4'd10) - YC_W'(YEAR_SHIFT + 1);

  assign ser_bits = acc[SER_W-1:0];
  assign ser_pad  = PAD_W'(ser_bits);
  assign dig_base = PB_W'({bi_r, 1'b0}) + PB_W'(bi_r);
  assign ser_dig  = ser_pad[dig_base +: 3];
  assign r7_step  = mod7_step({1'b0, r7_r} + {1'b0, ser_dig});

  assign diff_fits = (&acc[ACC_W-1:DIFF_W-1]) || !(|acc[ACC_W-1:DIFF_W-1]);

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    alu_op        = ALU_HOLD;
    alu_b         = '0;

    kind_nxt  = kind_r;
    ya_nxt    = ya_r;
    ma_nxt    = ma_r;
    da_nxt    = da_r;
    off_nxt   = off_r;
    yb_nxt    = yb_r;
    mb_nxt    = mb_r;
    db_nxt    = db_r;
    sel_b_nxt = sel_b_r;
    bad_nxt   = bad_r;
    yc_nxt    = yc_r;
    k_nxt     = k_r;
    k100_nxt  = k100_r;
    mp_nxt    = mp_r;
    bi_nxt    = bi_r;
    r7_nxt    = r7_r;
    save_nxt  = save_r;

    wk_year_nxt  = wk_year_r;
    wk_month_nxt = wk_month_r;
    wk_day_nxt   = wk_day_r;
    wk_diff_nxt  = wk_diff_r;
    wk_wday_nxt  = wk_wday_r;
    wk_inv_nxt   = wk_inv_r;
    wk_ovf_nxt   = wk_ovf_r;

    o_year_nxt  = o_year_r;
    o_month_nxt = o_month_r;
    o_day_nxt   = o_day_r;
    o_diff_nxt  = o_diff_r;
    o_wday_nxt  = o_wday_r;
    o_inv_nxt   = o_inv_r;
    o_ovf_nxt   = o_ovf_r;

    case (state_r)
      S_IDLE: begin
        if (in_chan.valid) begin
          kind_nxt     = in_chan.kind;
          ya_nxt       = in_chan.year_a;
          ma_nxt       = in_chan.month_a;
          da_nxt       = in_chan.day_a;
          off_nxt      = in_chan.offset_days;
          yb_nxt       = in_chan.year_b;
          mb_nxt       = in_chan.month_b;
          db_nxt       = in_chan.day_b;
          bad_nxt      = 1'b0;
          wk_year_nxt  = '0;
          wk_month_nxt = '0;
          wk_day_nxt   = '0;
          wk_diff_nxt  = '0;
          wk_wday_nxt  = '0;
          wk_inv_nxt   = 1'b0;
          wk_ovf_nxt   = 1'b0;
          // date b goes first so that date a ends in the accumulator
          sel_b_nxt    = (in_chan.kind == KIND_DIFF);
          if (!(in_chan.kind inside {KIND_SHIFT, KIND_DIFF, KIND_WDAY})) begin
            state_nxt = S_DONE;
          end else if (!date_range_ok(in_chan.month_a, in_chan.day_a) ||
                       ((in_chan.kind == KIND_DIFF) &&
                        !date_range_ok(in_chan.month_b, in_chan.day_b))) begin
            wk_inv_nxt = 1'b1;
            state_nxt  = S_DONE;
          end else begin
            state_nxt = S_LOAD;
          end
        end
      end

      S_LOAD: begin
        alu_op    = ALU_LOAD;
        alu_b     = ACC_W'(cur_doy);
        yc_nxt    = YC_W'(cur_y) + YC_W'(YEAR_SHIFT) - YC_W'(cur_m <= 4'd2);
        k_nxt     = 9'd1;
        k100_nxt  = 7'd1;
        state_nxt = S_ERA;
      end

      S_ERA: begin
        if (yc_r >= YC_W'(YEAR_SHIFT)) begin
          alu_op = ALU_ADD;
          alu_b  = ACC_W'(ERA_DAYS);
          yc_nxt = yc_r - YC_W'(YEAR_SHIFT);
        end else begin
          state_nxt = S_YEAR;
        end
      end

      S_YEAR: begin
        if (YC_W'(k_r) <= yc_r) begin
          alu_op   = ALU_ADD;
          alu_b    = ACC_W'(YEAR_DAYS) + ACC_W'(leap_k);
          k_nxt    = k_r + 9'd1;
          k100_nxt = (k100_r == 7'd99) ? 7'd0 : (k100_r + 7'd1);
        end else if (sel_b_r) begin
          bad_nxt   = bad_r || feb_bad;
          save_nxt  = acc;
          sel_b_nxt = 1'b0;
          state_nxt = S_LOAD;
        end else if (bad_r || feb_bad) begin
          wk_inv_nxt = 1'b1;
          state_nxt  = S_DONE;
        end else begin
          case (kind_r)
            KIND_SHIFT: state_nxt = S_SHIFT;
            KIND_DIFF:  state_nxt = S_DIFF;
            default: begin
              bi_nxt    = BI_W'(NDIG - 1);
              r7_nxt    = 3'd0;
              state_nxt = S_MOD;
            end
          endcase
        end
      end

      S_SHIFT: begin
        alu_op    = ALU_ADD;
        alu_b     = ACC_W'(off_r);
        state_nxt = S_CLO;
      end

      S_CLO: begin
        alu_op = ALU_MAX;
        alu_b  = ACC_W'(LO_SER);
        if (alu_hit) wk_ovf_nxt = 1'b1;
        state_nxt = S_CHI;
      end

      S_CHI: begin
        alu_op = ALU_MIN;
        alu_b  = ACC_W'(HI_SER);
        if (alu_hit) wk_ovf_nxt = 1'b1;
        yc_nxt    = '0;
        state_nxt = S_FERA;
      end

      S_FERA: begin
        alu_op = ALU_SUB_GE;
        alu_b  = ACC_W'(ERA_DAYS);
        if (alu_hit) begin
          yc_nxt = yc_r + YC_W'(YEAR_SHIFT);
        end else begin
          k_nxt     = 9'd1;
          k100_nxt  = 7'd1;
          state_nxt = S_FYEAR;
        end
      end

      S_FYEAR: begin
        alu_op = ALU_SUB_GE;
        alu_b  = ACC_W'(YEAR_DAYS) + ACC_W'(leap_k);
        if (alu_hit) begin
          k_nxt    = k_r + 9'd1;
          k100_nxt = (k100_r == 7'd99) ? 7'd0 : (k100_r + 7'd1);
        end else begin
          mp_nxt    = 4'd0;
          state_nxt = S_FMON;
        end
      end

      S_FMON: begin
        if (mp_r != MP_LAST) begin
          alu_op = ALU_SUB_GE;
          alu_b  = ACC_W'(march_len(mp_r));
        end
        if ((mp_r != MP_LAST) && alu_hit) begin
          mp_nxt = mp_r + 4'd1;
        end else begin
          wk_year_nxt  = res_yy[13:0];
          wk_month_nxt = res_mm;
          wk_day_nxt   = acc[4:0] + 5'd1;
          state_nxt    = S_DONE;
        end
      end

      S_DIFF: begin
        alu_op    = ALU_SUB;
        alu_b     = save_r;
        state_nxt = S_SAT;
      end

      S_SAT: begin
        if (diff_fits) begin
          wk_diff_nxt = acc[DIFF_W-1:0];
        end else begin
          wk_diff_nxt = acc[ACC_W-1] ? DIFF_MIN : DIFF_MAX;
        end
        state_nxt = S_DONE;
      end

      // serial modulo 7, one octal digit per cycle as 8 is 1 modulo 7
      S_MOD: begin
        r7_nxt = r7_step;
        if (bi_r == '0) begin
          wk_wday_nxt = (r7_step >= 3'(EPOCH_MOD7)) ? (r7_step - 3'(EPOCH_MOD7))
                                                     : (r7_step + 3'(7 - EPOCH_MOD7));
          state_nxt   = S_DONE;
        end else begin
          bi_nxt = bi_r - BI_W'(1);
        end
      end

      S_DONE: begin
        if (!out_valid_r || out_chan.ready) begin
          o_year_nxt    = wk_year_r;
          o_month_nxt   = wk_month_r;
          o_day_nxt     = wk_day_r;
          o_diff_nxt    = wk_diff_r;
          o_wday_nxt    = wk_wday_r;
          o_inv_nxt     = wk_inv_r;
          o_ovf_nxt     = wk_ovf_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r     <= kind_nxt;
    ya_r       <= ya_nxt;
    ma_r       <= ma_nxt;
    da_r       <= da_nxt;
    off_r      <= off_nxt;
    yb_r       <= yb_nxt;
    mb_r       <= mb_nxt;
    db_r       <= db_nxt;
    sel_b_r    <= sel_b_nxt;
    bad_r      <= bad_nxt;
    yc_r       <= yc_nxt;
    k_r        <= k_nxt;
    k100_r     <= k100_nxt;
    mp_r       <= mp_nxt;
    bi_r       <= bi_nxt;
    r7_r       <= r7_nxt;
    save_r     <= save_nxt;
    wk_year_r  <= wk_year_nxt;
    wk_month_r <= wk_month_nxt;
    wk_day_r   <= wk_day_nxt;
    wk_diff_r  <= wk_diff_nxt;
    wk_wday_r  <= wk_wday_nxt;
    wk_inv_r   <= wk_inv_nxt;
    wk_ovf_r   <= wk_ovf_nxt;
    o_year_r   <= o_year_nxt;
    o_month_r  <= o_month_nxt;
    o_day_r    <= o_day_nxt;
    o_diff_r   <= o_diff_nxt;
    o_wday_r   <= o_wday_nxt;
    o_inv_r    <= o_inv_nxt;
    o_ovf_r    <= o_ovf_nxt;
  end

  assign in_chan.ready           = (state_r == S_IDLE);
  assign out_chan.valid          = out_valid_r;
  assign out_chan.result_year    = o_year_r;
  assign out_chan.result_month   = o_month_r;
  assign out_chan.result_day     = o_day_r;
  assign out_chan.day_difference = o_diff_r;
  assign out_chan.weekday        = o_wday_r;
  assign out_chan.date_invalid   = o_inv_r;
  assign out_chan.year_overflow  = o_ovf_r;

  `GDA_ASSERT_NEXT(a_busy_after_req, clk, rst_n, in_chan.valid && in_chan.ready, !in_chan.ready, "block still ready after taking a request")
  `GDA_ASSERT(a_wday_range, clk, rst_n, out_chan.valid |-> (out_chan.weekday <= 3'd6), "weekday out of range")
  `GDA_ASSERT(a_invalid_clean, clk, rst_n, (out_chan.valid && out_chan.date_invalid) |-> ((out_chan.day_difference == '0) && !out_chan.year_overflow && (out_chan.result_month == '0)), "invalid date result carries data")

endmodule
